// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files of the tile mean downsampler.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define TMD_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Clocked assertion that stays active through reset.
`define TMD_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

// ===== sv/tmd_pkg.sv =====
// Package of the tile mean downsampler: field widths, defaults, register
// indexes and the types shared by the top level and the divider.
// No dependencies.
package tmd_pkg;

   localparam int DEF_MAX_IMAGE_WIDTH = 4096;
   localparam int DEF_MAX_TILE_SIZE   = 64;

   localparam int PIX_W      = 32;
   localparam int IDX_OUT_W  = 12;
   localparam int CFG_IMG_W  = 13;
   localparam int CFG_TILE_W = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CFG_IMG_W-1:0]  RST_IMAGE_WIDTH  = 13'd2048;
   localparam logic [CFG_IMG_W-1:0]  RST_IMAGE_HEIGHT = 13'd2048;
   localparam logic [CFG_TILE_W-1:0] RST_TILE_WIDTH   = 7'd10;
   localparam logic [CFG_TILE_W-1:0] RST_TILE_HEIGHT  = 7'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_TILE_WIDTH,
      CSR_TILE_HEIGHT
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] tile_column;
      logic [IDX_OUT_W-1:0] tile_row;
      logic                 frame_done;
   } tile_tag_type;

   typedef struct packed {
      tile_tag_type            tag;
      logic signed [PIX_W-1:0] mean_value;
      logic                    mean_valid;
   } div_result_type;

endpackage

// ===== sv/tmd_divider.sv =====
// Sequential signed divider of the tile mean downsampler: tile sum by pixel
// count, one quotient bit per cycle, truncated toward zero.
// Depends on tmd_pkg.
module tmd_divider #(
   parameter int SUM_W = 44,
   parameter int CNT_W = 13
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SUM_W-1:0]       dividend,
   input  logic [CNT_W-1:0]       divisor,
   input  tmd_pkg::tile_tag_type  start_tag,
   output logic                   busy,
   output logic                   done,
   input  logic                   take,
   output tmd_pkg::div_result_type result
);

   localparam int StepW = $clog2(SUM_W);

   tmd_pkg::div_state_type state_ff, state_in;
   logic [SUM_W-1:0]      quo_ff, quo_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic [StepW-1:0]      step_ff, step_in;
   tmd_pkg::tile_tag_type tag_ff, tag_in;

   logic [CNT_W:0]               trial;
   logic                         fits;
   logic [tmd_pkg::PIX_W-1:0]    mag;

   // Restoring step: bring down the next dividend bit and try a subtract.
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign mag   = quo_ff[tmd_pkg::PIX_W-1:0];

   always_comb begin
      state_in = state_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      tag_in   = tag_ff;
      unique case (state_ff)
         tmd_pkg::DIV_IDLE: begin
            if (start) begin
               neg_in  = dividend[SUM_W-1];
               quo_in  = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
               rem_in  = '0;
               den_in  = divisor;
               step_in = StepW'(SUM_W - 1);
               tag_in  = start_tag;
               // An empty tile needs no quotient.
               state_in = (divisor == '0) ? tmd_pkg::DIV_DONE : tmd_pkg::DIV_RUN;
            end
         end
         tmd_pkg::DIV_RUN: begin
            rem_in  = fits ? CNT_W'(trial - {1'b0, den_ff}) : CNT_W'(trial);
            quo_in  = {quo_ff[SUM_W-2:0], fits};
            step_in = step_ff - StepW'(1);
            if (step_ff == '0) begin
               state_in = tmd_pkg::DIV_DONE;
            end
         end
         tmd_pkg::DIV_DONE: begin
            if (take) begin
               state_in = tmd_pkg::DIV_IDLE;
            end
         end
         default: begin
            state_in = tmd_pkg::DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmd_pkg::DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
      tag_ff  <= tag_in;
   end

   assign busy = state_ff != tmd_pkg::DIV_IDLE;
   assign done = state_ff == tmd_pkg::DIV_DONE;

   always_comb begin
      result.tag        = tag_ff;
      result.mean_valid = den_ff != '0;
      if (den_ff == '0) begin
         result.mean_value = '0;
      end else if (neg_ff) begin
         result.mean_value = -mag;
      end else begin
         result.mean_value = mag;
      end
   end

endmodule

// ===== sv/tile_mean_downsampler_top.sv =====
// A tile's last pixel passes the update stage, the divider and the output register to rsp_valid.
// Throughput: one pixel per cycle; a tile's last pixel occupies the shared divider until its
// result is taken, and another last pixel arriving meanwhile waits for it and stalls the input.
// Reset (synchronous, active high) restores the default geometry, clears all raster counters and
// empties the pipeline; the accumulator memory keeps its contents and needs no clearing.
module tile_mean_downsampler_top #(
   parameter int MAX_IMAGE_WIDTH = tmd_pkg::DEF_MAX_IMAGE_WIDTH,
   parameter int MAX_TILE_SIZE   = tmd_pkg::DEF_MAX_TILE_SIZE
) (
   input  logic                                clock,
   input  logic                                reset,
   // Pixel input transactions.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [tmd_pkg::PIX_W-1:0]    req_pixel_value,
   input  logic                                req_pixel_valid,
   // Tile result transactions.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tmd_pkg::IDX_OUT_W-1:0]       rsp_tile_column,
   output logic [tmd_pkg::IDX_OUT_W-1:0]       rsp_tile_row,
   output logic signed [tmd_pkg::PIX_W-1:0]    rsp_mean_value,
   output logic                                rsp_mean_valid,
   output logic                                rsp_frame_done,
   // Register write port.
   input  logic                                csr_write_enable,
   input  logic [tmd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tmd_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   // Counter widths follow the largest image and tile the block supports.
   localparam int ColW  = $clog2(MAX_IMAGE_WIDTH);
   localparam int ImgW  = $clog2(MAX_IMAGE_WIDTH + 1);
   localparam int CitW  = $clog2(MAX_TILE_SIZE);
   localparam int TileW = $clog2(MAX_TILE_SIZE + 1);
   localparam int CntW  = $clog2(MAX_TILE_SIZE * MAX_TILE_SIZE + 1);
   localparam int SumW  = tmd_pkg::PIX_W - 1 + CntW;
   localparam int PrdW  = ColW + TileW + 2;

   // ---------------------------------------------------------------------
   // Configuration registers. Values out of range are clamped on use, so
   // the raw value written is kept as it is.
   // ---------------------------------------------------------------------
   logic [tmd_pkg::CFG_IMG_W-1:0]  image_width_ff, image_width_in;
   logic [tmd_pkg::CFG_IMG_W-1:0]  image_height_ff, image_height_in;
   logic [tmd_pkg::CFG_TILE_W-1:0] tile_width_ff, tile_width_in;
   logic [tmd_pkg::CFG_TILE_W-1:0] tile_height_ff, tile_height_in;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      tile_width_in   = tile_width_ff;
      tile_height_in  = tile_height_ff;
      if (csr_write_enable) begin
         unique case (tmd_pkg::csr_index_type'(csr_index))
            tmd_pkg::CSR_IMAGE_WIDTH:  image_width_in  = csr_write_data;
            tmd_pkg::CSR_IMAGE_HEIGHT: image_height_in = csr_write_data;
            tmd_pkg::CSR_TILE_WIDTH:   tile_width_in   = csr_write_data[tmd_pkg::CFG_TILE_W-1:0];
            tmd_pkg::CSR_TILE_HEIGHT:  tile_height_in  = csr_write_data[tmd_pkg::CFG_TILE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective geometry: zero counts as one, anything above the maximum is
   // taken as the maximum.
   logic [ImgW-1:0]  w_eff, h_eff;
   logic [TileW-1:0] tw_eff, th_eff;

   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = ImgW'(1);
      end else if (int'(image_width_ff) > MAX_IMAGE_WIDTH) begin
         w_eff = ImgW'(MAX_IMAGE_WIDTH);
      end else begin
         w_eff = ImgW'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         h_eff = ImgW'(1);
      end else if (int'(image_height_ff) > MAX_IMAGE_WIDTH) begin
         h_eff = ImgW'(MAX_IMAGE_WIDTH);
      end else begin
         h_eff = ImgW'(image_height_ff);
      end
      if (tile_width_ff == '0) begin
         tw_eff = TileW'(1);
      end else if (int'(tile_width_ff) > MAX_TILE_SIZE) begin
         tw_eff = TileW'(MAX_TILE_SIZE);
      end else begin
         tw_eff = TileW'(tile_width_ff);
      end
      if (tile_height_ff == '0) begin
         th_eff = TileW'(1);
      end else if (int'(tile_height_ff) > MAX_TILE_SIZE) begin
         th_eff = TileW'(MAX_TILE_SIZE);
      end else begin
         th_eff = TileW'(tile_height_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Raster counters. They move on every accepted transaction, whether or
   // not the pixel falls into a complete tile.
   // ---------------------------------------------------------------------
   logic [ColW-1:0] pix_col_ff, pix_col_in;
   logic [ColW-1:0] pix_row_ff, pix_row_in;
   logic [CitW-1:0] col_in_tile_ff, col_in_tile_in;
   logic [CitW-1:0] row_in_tile_ff, row_in_tile_in;
   logic [ColW-1:0] tile_col_ff, tile_col_in;
   logic [ColW-1:0] tile_row_ff, tile_row_in;

   logic accept;
   logic col_tile_wrap, row_tile_wrap, line_wrap, frame_wrap;

   assign accept        = req_valid && !req_stall;
   assign col_tile_wrap = (TileW'(col_in_tile_ff) + TileW'(1)) >= tw_eff;
   assign row_tile_wrap = (TileW'(row_in_tile_ff) + TileW'(1)) >= th_eff;
   assign line_wrap     = (ImgW'(pix_col_ff) + ImgW'(1)) >= w_eff;
   assign frame_wrap    = (ImgW'(pix_row_ff) + ImgW'(1)) >= h_eff;

   always_comb begin
      pix_col_in     = pix_col_ff;
      pix_row_in     = pix_row_ff;
      col_in_tile_in = col_in_tile_ff;
      row_in_tile_in = row_in_tile_ff;
      tile_col_in    = tile_col_ff;
      tile_row_in    = tile_row_ff;
      if (accept) begin
         if (col_tile_wrap) begin
            col_in_tile_in = '0;
            tile_col_in    = tile_col_ff + ColW'(1);
         end else begin
            col_in_tile_in = col_in_tile_ff + CitW'(1);
         end
         if (line_wrap) begin
            pix_col_in     = '0;
            col_in_tile_in = '0;
            tile_col_in    = '0;
            if (row_tile_wrap) begin
               row_in_tile_in = '0;
               tile_row_in    = tile_row_ff + ColW'(1);
            end else begin
               row_in_tile_in = row_in_tile_ff + CitW'(1);
            end
            if (frame_wrap) begin
               pix_row_in     = '0;
               row_in_tile_in = '0;
               tile_row_in    = '0;
            end else begin
               pix_row_in = pix_row_ff + ColW'(1);
            end
         end else begin
            pix_col_in = pix_col_ff + ColW'(1);
         end
      end
   end

   // A tile is complete when its far edge lies inside the image. The tile after it not
   // fitting means this is the last tile of its line or band; both at once close the frame.
   logic [PrdW-1:0] col_start, col_end, col_next_end;
   logic [PrdW-1:0] row_start, row_end, row_next_end;
   logic            in_tile, last_pixel;
   tmd_pkg::tile_tag_type acc_tag;

   assign col_start    = PrdW'(tile_col_ff) * PrdW'(tw_eff);
   assign col_end      = col_start + PrdW'(tw_eff);
   assign col_next_end = col_end + PrdW'(tw_eff);
   assign row_start    = PrdW'(tile_row_ff) * PrdW'(th_eff);
   assign row_end      = row_start + PrdW'(th_eff);
   assign row_next_end = row_end + PrdW'(th_eff);

   assign in_tile    = (col_end <= PrdW'(w_eff)) && (row_end <= PrdW'(h_eff));
   assign last_pixel = ((TileW'(col_in_tile_ff) + TileW'(1)) == tw_eff) &&
                       ((TileW'(row_in_tile_ff) + TileW'(1)) == th_eff);

   assign acc_tag.tile_column = tmd_pkg::IDX_OUT_W'(tile_col_ff);
   assign acc_tag.tile_row    = tmd_pkg::IDX_OUT_W'(tile_row_ff);
   assign acc_tag.frame_done  = (col_next_end > PrdW'(w_eff)) &&
                                (row_next_end > PrdW'(h_eff));

   // ---------------------------------------------------------------------
   // Accumulator memory, one entry per tile column. The read is issued at
   // acceptance; the update is written back when the update stage advances.
   // ---------------------------------------------------------------------
   logic [SumW-1:0] sum_mem [MAX_IMAGE_WIDTH];
   logic [CntW-1:0] cnt_mem [MAX_IMAGE_WIDTH];
   logic [SumW-1:0] rd_sum_ff;
   logic [CntW-1:0] rd_cnt_ff;

   // Update stage: holds one accepted pixel of a complete tile while its
   // accumulator entry is read.
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_first_row_ff;
   logic                          s1_last_ff;
   logic [tmd_pkg::PIX_W-1:0]     s1_pix_ff;
   logic                          s1_pix_valid_ff;
   logic [ColW-1:0]               s1_addr_ff;
   tmd_pkg::tile_tag_type         s1_tag_ff;

   // Write-back forwarding: when the previous pixel wrote the entry that
   // this one read in the same cycle, the memory returned the old data.
   logic                          fwd_hit_ff, fwd_hit_in;
   logic [SumW-1:0]               fwd_sum_ff;
   logic [CntW-1:0]               fwd_cnt_ff;

   logic                          load_s1;
   logic                          s1_adv;
   logic                          div_busy, div_done, div_take;
   logic [SumW-1:0]               cur_sum, pix_ext, new_sum;
   logic [CntW-1:0]               cur_cnt, new_cnt;

   // The stage only stalls when it carries a tile's last pixel and the
   // divider still works on the previous tile.
   assign s1_adv    = s1_valid_ff && !(s1_last_ff && div_busy);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign load_s1   = accept && in_tile;

   assign s1_valid_in = load_s1 ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign fwd_hit_in  = load_s1 && s1_adv && (s1_addr_ff == tile_col_ff);

   assign cur_sum = fwd_hit_ff ? fwd_sum_ff : rd_sum_ff;
   assign cur_cnt = fwd_hit_ff ? fwd_cnt_ff : rd_cnt_ff;
   assign pix_ext = s1_pix_valid_ff ?
                    {{(SumW - tmd_pkg::PIX_W){s1_pix_ff[tmd_pkg::PIX_W-1]}}, s1_pix_ff} : '0;

   // The first row of a tile band starts the entry afresh; NaN pixels add
   // nothing to the sum or the count.
   assign new_sum = s1_first_row_ff ? pix_ext : (cur_sum + pix_ext);
   assign new_cnt = s1_first_row_ff ? CntW'(s1_pix_valid_ff) :
                    (cur_cnt + CntW'(s1_pix_valid_ff));

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         sum_mem[s1_addr_ff] <= new_sum;
         cnt_mem[s1_addr_ff] <= new_cnt;
      end
      if (load_s1) begin
         rd_sum_ff <= sum_mem[tile_col_ff];
         rd_cnt_ff <= cnt_mem[tile_col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_first_row_ff <= row_in_tile_ff == '0;
         s1_last_ff      <= last_pixel;
         s1_pix_ff       <= req_pixel_value;
         s1_pix_valid_ff <= req_pixel_valid;
         s1_addr_ff      <= tile_col_ff;
         s1_tag_ff       <= acc_tag;
         fwd_sum_ff      <= new_sum;
         fwd_cnt_ff      <= new_cnt;
      end
   end

   // ---------------------------------------------------------------------
   // Divider: the finished tile's sum and count go to the shared divider
   // as the last pixel's update is written back.
   // ---------------------------------------------------------------------
   tmd_pkg::div_result_type div_result;

   tmd_divider #(
      .SUM_W (SumW),
      .CNT_W (CntW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (s1_adv && s1_last_ff),
      .dividend  (new_sum),
      .divisor   (new_cnt),
      .start_tag (s1_tag_ff),
      .busy      (div_busy),
      .done      (div_done),
      .take      (div_take),
      .result    (div_result)
   );

   // ---------------------------------------------------------------------
   // Output register. It takes the divider result whenever it is empty or
   // its transaction completes in the same cycle.
   // ---------------------------------------------------------------------
   logic rsp_valid_ff, rsp_valid_in;
   tmd_pkg::div_result_type rsp_data_ff;

   assign div_take     = div_done && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = div_take ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (div_take) begin
         rsp_data_ff <= div_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tile_column = rsp_data_ff.tag.tile_column;
   assign rsp_tile_row    = rsp_data_ff.tag.tile_row;
   assign rsp_mean_value  = rsp_data_ff.mean_value;
   assign rsp_mean_valid  = rsp_data_ff.mean_valid;
   assign rsp_frame_done  = rsp_data_ff.tag.frame_done;

   // ---------------------------------------------------------------------
   // Control registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= tmd_pkg::RST_IMAGE_WIDTH;
         image_height_ff <= tmd_pkg::RST_IMAGE_HEIGHT;
         tile_width_ff   <= tmd_pkg::RST_TILE_WIDTH;
         tile_height_ff  <= tmd_pkg::RST_TILE_HEIGHT;
         pix_col_ff      <= '0;
         pix_row_ff      <= '0;
         col_in_tile_ff  <= '0;
         row_in_tile_ff  <= '0;
         tile_col_ff     <= '0;
         tile_row_ff     <= '0;
         s1_valid_ff     <= 1'b0;
         fwd_hit_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         tile_width_ff   <= tile_width_in;
         tile_height_ff  <= tile_height_in;
         pix_col_ff      <= pix_col_in;
         pix_row_ff      <= pix_row_in;
         col_in_tile_ff  <= col_in_tile_in;
         row_in_tile_ff  <= row_in_tile_in;
         tile_col_ff     <= tile_col_in;
         tile_row_ff     <= tile_row_in;
         s1_valid_ff     <= s1_valid_in;
         // Forwarding only matters for the pixel just loaded.
         fwd_hit_ff      <= load_s1 ? fwd_hit_in : fwd_hit_ff;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/tmd_checker.sv =====
// Port-level checks of the tile mean downsampler, bound to its top level.
// Depends on tmd_pkg, assert_macros.svh and tile_mean_downsampler_top.
`include "assert_macros.svh"

module tmd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [tmd_pkg::IDX_OUT_W-1:0]    rsp_tile_column,
   input logic signed [tmd_pkg::PIX_W-1:0] rsp_mean_value,
   input logic                             rsp_mean_valid
);

   // Reset leaves no result pending and the input side open.
   `TMD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall)

   // A tile without a valid pixel reports a zero mean.
   `TMD_ASSERT(a_empty_tile_zero, clock, reset, rsp_valid && !rsp_mean_valid |-> rsp_mean_value == '0)

   // A stalled result transaction stays and holds its payload.
   `TMD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mean_value) && $stable(rsp_tile_column))

endmodule

bind tile_mean_downsampler_top tmd_checker u_tmd_checker (.*);

// ===== tb/sv/tb_tile_mean_downsampler_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the tile mean downsampler: raster-order pixel frames go in,
// per-tile means are predicted in order and compared with every result transaction.
// Depends on tmd_pkg and tile_mean_downsampler_top.
module tb_tile_mean_downsampler_top;
   import tmd_pkg::*;

   localparam int MAX_IMG         = DEF_MAX_IMAGE_WIDTH;
   localparam int MAX_TILE        = DEF_MAX_TILE_SIZE;
   localparam int SUM_W           = 44;
   localparam int COUNT_W         = 13;
   // A tile result passes the update stage, the divider and the output register, so a pause
   // of this length after the last result guarantees that nothing is still in flight.
   localparam int SETTLE_CYCLES   = 60;
   localparam int DRAIN_CYCLES    = 100;
   // The divider works on one tile at a time and the result side stalls at random, yet a
   // gap between transactions stays far below this.
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_PIXELS   = 780;
   localparam int NORMAL_IDLE_PCT = 36;

   localparam logic signed [PIX_W-1:0] PIX_MAX = 32'h7FFF_FFFF;
   localparam logic signed [PIX_W-1:0] PIX_MIN = 32'h8000_0000;

   typedef enum {MIX_VALUES, ALL_MIN} value_mix_t;

   typedef struct {
      logic signed [PIX_W-1:0] value;
      logic                    valid;
   } pixel_t;

   typedef struct {
      logic [IDX_OUT_W-1:0]    column;
      logic [IDX_OUT_W-1:0]    row;
      logic signed [PIX_W-1:0] mean;
      logic                    mean_valid;
      logic                    frame_done;
   } tile_mean_t;

   // Every input of the block has a known value from time zero.
   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic                    req_stall;
   logic signed [PIX_W-1:0] req_pixel_value  = '0;
   logic                    req_pixel_valid  = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall        = 1'b0;
   logic [IDX_OUT_W-1:0]    rsp_tile_column;
   logic [IDX_OUT_W-1:0]    rsp_tile_row;
   logic signed [PIX_W-1:0] rsp_mean_value;
   logic                    rsp_mean_valid;
   logic                    rsp_frame_done;
   logic                    csr_write_enable = 1'b0;
   csr_index_type           csr_index        = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]   csr_write_data   = '0;

   // Pixels waiting to be sent, tile results waiting to be seen, and run bookkeeping.
   pixel_t     pixel_backlog[$];
   tile_mean_t expected_means[$];
   pixel_t     next_pixel;
   tile_mean_t oldest_mean;
   int         mismatches    = 0;
   int         quiet_cycles  = 0;
   int         req_idle_pct  = NORMAL_IDLE_PCT;
   int         rsp_stall_pct = NORMAL_IDLE_PCT;

   // Shadow of the geometry registers, holding the raw written values.
   logic [CFG_IMG_W-1:0]  geo_image_width  = RST_IMAGE_WIDTH;
   logic [CFG_IMG_W-1:0]  geo_image_height = RST_IMAGE_HEIGHT;
   logic [CFG_TILE_W-1:0] geo_tile_width   = RST_TILE_WIDTH;
   logic [CFG_TILE_W-1:0] geo_tile_height  = RST_TILE_HEIGHT;

   // Shadow of the accumulator store and the raster counters. The store entries are
   // always written by the first row of a band before they are read.
   logic signed [SUM_W-1:0] band_sum[MAX_IMG];
   logic [COUNT_W-1:0]      band_count[MAX_IMG];
   logic [11:0]             col_pos     = '0;
   logic [11:0]             row_pos     = '0;
   logic [5:0]              col_in_tile = '0;
   logic [5:0]              row_in_tile = '0;
   logic [11:0]             tile_col    = '0;
   logic [11:0]             tile_row    = '0;

   tile_mean_downsampler_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_value  (req_pixel_value),
      .req_pixel_valid  (req_pixel_valid),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tile_column  (rsp_tile_column),
      .rsp_tile_row     (rsp_tile_row),
      .rsp_mean_value   (rsp_mean_value),
      .rsp_mean_valid   (rsp_mean_valid),
      .rsp_frame_done   (rsp_frame_done),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // A register value of zero acts as one, and values above the maximum act as the maximum.
   function automatic int clamp_geometry(int raw, int hi);
      if (raw == 0) return 1;
      return (raw > hi) ? hi : raw;
   endfunction

   // Folds one accepted pixel into the shadow store, queues the tile mean when the pixel
   // closes a complete tile, and advances the raster counters.
   function automatic void accumulate_pixel(logic signed [PIX_W-1:0] value, logic valid);
      int         w;
      int         h;
      int         tw;
      int         th;
      int         across;
      int         down;
      longint     quotient;
      tile_mean_t result;
      w      = clamp_geometry(geo_image_width, MAX_IMG);
      h      = clamp_geometry(geo_image_height, MAX_IMG);
      tw     = clamp_geometry(geo_tile_width, MAX_TILE);
      th     = clamp_geometry(geo_tile_height, MAX_TILE);
      across = w / tw;
      down   = h / th;

      // Pixels of partial tiles at the right and bottom edges never touch the store.
      if (tile_col < across && tile_row < down) begin
         if (row_in_tile == 0) begin
            // The first row of a band restarts the entry, even for a NaN pixel.
            if (valid) begin
               band_sum[tile_col]   = value;
               band_count[tile_col] = 1;
            end else begin
               band_sum[tile_col]   = '0;
               band_count[tile_col] = 0;
            end
         end else if (valid) begin
            band_sum[tile_col]   = band_sum[tile_col] + value;
            band_count[tile_col] = band_count[tile_col] + 1'b1;
         end
         if (col_in_tile == tw - 1 && row_in_tile == th - 1) begin
            quotient = 0;
            // Signed division truncates toward zero, as the block must.
            if (band_count[tile_col] != 0)
               quotient = longint'(band_sum[tile_col]) / longint'(band_count[tile_col]);
            result.column     = tile_col;
            result.row        = tile_row;
            result.mean       = quotient[PIX_W-1:0];
            result.mean_valid = (band_count[tile_col] != 0);
            result.frame_done = (tile_col == across - 1 && tile_row == down - 1);
            expected_means.push_back(result);
         end
      end

      // Every wrap test is "reached or passed", so counters fall back into range.
      if (col_in_tile + 1 >= tw) begin
         col_in_tile = 0;
         tile_col    = tile_col + 1'b1;
      end else begin
         col_in_tile = col_in_tile + 1'b1;
      end
      if (col_pos + 1 >= w) begin
         col_pos     = 0;
         col_in_tile = 0;
         tile_col    = 0;
         if (row_in_tile + 1 >= th) begin
            row_in_tile = 0;
            tile_row    = tile_row + 1'b1;
         end else begin
            row_in_tile = row_in_tile + 1'b1;
         end
         if (row_pos + 1 >= h) begin
            // End of frame: everything returns to the top left corner.
            row_pos     = 0;
            row_in_tile = 0;
            tile_row    = 0;
         end else begin
            row_pos = row_pos + 1'b1;
         end
      end else begin
         col_pos = col_pos + 1'b1;
      end
   endfunction

   // Reports a field that differs from the expectation; X or Z on the port counts as a
   // difference too.
   function automatic void compare_field(string field, logic signed [PIX_W:0] want,
                                         logic signed [PIX_W:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   function automatic pixel_t random_pixel(int nan_pct, value_mix_t mix);
      pixel_t px;
      px.valid = ($urandom_range(0, 99) >= nan_pct);
      if (mix == ALL_MIN) begin
         px.value = PIX_MIN;
         px.valid = 1'b1;
      end else begin
         case ($urandom_range(0, 9))
            0:          px.value = PIX_MAX;
            1:          px.value = PIX_MIN;
            2, 3, 4, 5: px.value = $urandom();
            default:    px.value = int'($urandom_range(0, 2_000_000)) - 1_000_000;
         endcase
      end
      return px;
   endfunction

   // Driver: a new pixel is offered only when the current one has been taken (or none is
   // up), so a stalled transaction keeps its valid and its payload. Whether to idle is
   // decided without looking at the stall.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            accumulate_pixel(req_pixel_value, req_pixel_valid);
         if (!req_valid || !req_stall) begin
            if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
               next_pixel = pixel_backlog.pop_front();
               req_valid       <= 1'b1;
               req_pixel_value <= next_pixel.value;
               req_pixel_valid <= next_pixel.valid;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: every accepted tile result is matched against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_means.size() == 0) begin
               $display("%0t: tile result (column %0d, row %0d) with nothing expected",
                        $time, rsp_tile_column, rsp_tile_row);
               mismatches++;
            end else begin
               oldest_mean = expected_means.pop_front();
               compare_field("tile_column", oldest_mean.column, rsp_tile_column);
               compare_field("tile_row", oldest_mean.row, rsp_tile_row);
               compare_field("mean_value", oldest_mean.mean, rsp_mean_value);
               compare_field("mean_valid", oldest_mean.mean_valid, rsp_mean_valid);
               compare_field("frame_done", oldest_mean.frame_done, rsp_frame_done);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // Counts cycles in which no transaction of any kind completes.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // One register write; the shadow copy follows once the write has taken effect.
   task automatic write_register(csr_index_type idx, int value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  geo_image_width  = value[CFG_IMG_W-1:0];
         CSR_IMAGE_HEIGHT: geo_image_height = value[CFG_IMG_W-1:0];
         CSR_TILE_WIDTH:   geo_tile_width   = value[CFG_TILE_W-1:0];
         CSR_TILE_HEIGHT:  geo_tile_height  = value[CFG_TILE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(int w, int h, int tw, int th);
      write_register(CSR_IMAGE_WIDTH, w);
      write_register(CSR_IMAGE_HEIGHT, h);
      write_register(CSR_TILE_WIDTH, tw);
      write_register(CSR_TILE_HEIGHT, th);
   endtask

   task automatic queue_pixel(logic signed [PIX_W-1:0] value, logic valid);
      pixel_t px;
      px.value = value;
      px.valid = valid;
      pixel_backlog.push_back(px);
   endtask

   // Queues one whole frame at the current geometry, so that the raster counters are back
   // at the top left corner once it has been sent.
   task automatic queue_frame(int nan_pct, value_mix_t mix);
      int pixels;
      pixels = clamp_geometry(geo_image_width, MAX_IMG) *
               clamp_geometry(geo_image_height, MAX_IMG);
      repeat (pixels)
         pixel_backlog.push_back(random_pixel(nan_pct, mix));
   endtask

   // Waits until every pixel has been taken and every expected result has arrived, then
   // lets the pipeline run empty for the given number of cycles.
   task automatic wait_for_drain(int extra);
      while (pixel_backlog.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_means.size() != 0)
         @(posedge clock);
      repeat (extra)
         @(posedge clock);
   endtask

   // A one-pixel frame: its single pixel wraps every counter back to the top left corner,
   // wherever the previous geometry left them.
   task automatic return_to_origin();
      set_geometry(1, 1, 1, 1);
      queue_pixel('0, 1'b0);
      wait_for_drain(SETTLE_CYCLES);
   endtask

   initial begin
      int w;
      int h;
      int tw;
      int th;
      int frames;
      int frame_pixels;
      int nan_pct;
      int random_pixels;
      random_pixels = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // A 4x2 image of 2x2 tiles: the left tile is all full-scale positive values, the
      // right tile holds only NaN pixels whose value bits must be ignored.
      set_geometry(4, 2, 2, 2);
      queue_pixel(PIX_MAX, 1'b1);
      queue_pixel(PIX_MAX, 1'b1);
      queue_pixel(32'h1234_5678, 1'b0);
      queue_pixel(32'hFFFF_FFFF, 1'b0);
      queue_pixel(PIX_MAX, 1'b1);
      queue_pixel(PIX_MAX, 1'b1);
      queue_pixel(PIX_MAX, 1'b0);
      queue_pixel(PIX_MIN, 1'b0);
      wait_for_drain(SETTLE_CYCLES);

      // Tiles wider than the image never complete, and a zero tile height acts as one.
      set_geometry(2, 2, 5, 0);
      repeat (4) pixel_backlog.push_back(random_pixel(0, MIX_VALUES));
      wait_for_drain(SETTLE_CYCLES);

      // A height change in the middle of a frame. The left tile starts with a NaN that
      // must still clear the old full-scale sum; the right tile checks that a negative
      // mean of -7/3 truncates toward zero. Shrinking the height to two rows makes the
      // right tile the last one of the frame.
      set_geometry(4, 4, 2, 2);
      queue_pixel(PIX_MIN, 1'b0);
      queue_pixel(PIX_MIN, 1'b1);
      queue_pixel(-3, 1'b1);
      queue_pixel($urandom(), 1'b0);
      queue_pixel(PIX_MIN, 1'b1);
      queue_pixel(PIX_MIN, 1'b1);
      wait_for_drain(SETTLE_CYCLES);
      write_register(CSR_IMAGE_HEIGHT, 2);
      queue_pixel(1, 1'b1);
      queue_pixel(-5, 1'b1);
      wait_for_drain(SETTLE_CYCLES);

      // All registers zero: single-pixel frames, each a tile that closes its own frame.
      set_geometry(0, 0, 0, 0);
      repeat (30) queue_frame(25, MIX_VALUES);
      wait_for_drain(SETTLE_CYCLES);

      // Oversized width and tile width clamp to 4096 and 64. The first three tiles of the
      // line run with no idling on either side, so the block sees a long unbroken stream.
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      set_geometry(8191, 1, 127, 0);
      repeat (192) pixel_backlog.push_back(random_pixel(10, MIX_VALUES));
      wait_for_drain(SETTLE_CYCLES);
      req_idle_pct  = NORMAL_IDLE_PCT;
      rsp_stall_pct = NORMAL_IDLE_PCT;
      return_to_origin();

      // The tallest image, one pixel wide, with the tallest tiles: two tiles of it.
      set_geometry(1, 4096, 1, 64);
      repeat (128) pixel_backlog.push_back(random_pixel(20, MIX_VALUES));
      wait_for_drain(SETTLE_CYCLES);
      return_to_origin();

      // One 64x2 tile of the most negative value: a deeply negative sum whose mean is the
      // bottom of the output range.
      set_geometry(64, 2, 64, 2);
      queue_frame(0, ALL_MIN);
      wait_for_drain(SETTLE_CYCLES);

      // Random small geometries, whole frames each, with varying NaN density and
      // occasional phases where one side never idles.
      while (random_pixels < RANDOM_PIXELS) begin
         w  = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 14);
         h  = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 10);
         tw = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6);
         th = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6);
         case ($urandom_range(0, 4))
            0:       nan_pct = 0;
            1:       nan_pct = 10;
            2:       nan_pct = 35;
            3:       nan_pct = 80;
            default: nan_pct = 100;
         endcase
         req_idle_pct  = ($urandom_range(0, 5) == 0) ? 0 : NORMAL_IDLE_PCT;
         rsp_stall_pct = ($urandom_range(0, 5) == 0) ? 0 : NORMAL_IDLE_PCT;
         set_geometry(w, h, tw, th);
         frame_pixels = clamp_geometry(w, MAX_IMG) * clamp_geometry(h, MAX_IMG);
         frames       = 60 / frame_pixels + 1;
         repeat (frames) queue_frame(nan_pct, MIX_VALUES);
         random_pixels += frames * frame_pixels;
         wait_for_drain(SETTLE_CYCLES);
      end

      // Everything has been sent and matched; a last quiet stretch catches stray results.
      wait_for_drain(DRAIN_CYCLES);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== tile_mean_downsampler_top.f =====
+incdir+sv
sv/tmd_pkg.sv
sv/tmd_divider.sv
sv/tile_mean_downsampler_top.sv
sv/tmd_checker.sv
tb/sv/tb_tile_mean_downsampler_top.sv
